### src/bpa_pkg.sv
// Package: payload structs, request and status codes, default sizes.
`default_nettype none
package bpa_pkg;
  localparam int unsigned MaxPagesDef = 4096;
  localparam logic [12:0] TotalReset = 13'd4096;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_RESERVE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] start_page;
    logic [12:0] page_count;
    logic [12:0] align_pages;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] result_page;
  } rsp_t;
endpackage
`default_nettype wire

### src/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bpa_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

### src/bitmap_page_allocator.sv
// Top level: next-fit contiguous page allocator over a one-bit-per-page used map.
// Allocate steps through candidate starts (a pass change is one step), reads then
//   checks each page of a candidate, marks the pages found, then returns the result.
// Free/reserve write each page in the clipped range, then return; errors go straight to the result.
// Throughput: one word at a time; next word is taken once the result is queued.
// Reset: a clearing pass writes every map entry to free, with no word accepted
//   meanwhile; config writes are taken throughout.
`default_nettype none
module bitmap_page_allocator #(
  parameter int unsigned MAX_PAGES = bpa_pkg::MaxPagesDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire bpa_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output bpa_pkg::rsp_t      out_rsp_o,
  input  wire logic          cfg_we_i,
  input  wire logic [12:0]   cfg_wdata_i
);
  // Page index width and a wide working width for sums like cand + count.
  localparam int unsigned PW = $clog2(MAX_PAGES);
  localparam int unsigned AW = ((PW > 13) ? PW : 13) + 2;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_CAND = 7'b0000100,
    S_RD   = 7'b0001000,
    S_CHK  = 7'b0010000,
    S_FILL = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [12:0]     total_q;
  logic [PW-1:0]   last_q, last_d;
  logic [PW-1:0]   clr_q, clr_d;
  logic [AW-1:0]   cand_q, cand_d, t_q, t_d, hi_q, hi_d, end_q, end_d, cnt_q, cnt_d;
  logic [AW-1:0]   amask_q, amask_d;
  logic            pass_q, pass_d, wval_q, wval_d;
  logic [1:0]      status_q, status_d;
  logic [11:0]     page_q, page_d;
  logic            out_valid_q, out_valid_d;
  bpa_pkg::rsp_t   out_rsp_q, out_rsp_d;

  logic            ram_we, ram_wdata, ram_re, ram_rdata;
  logic [PW-1:0]   ram_waddr, ram_raddr;
  logic [AW-1:0]   tot_eff, run_end, t_next;

  // Round v up to the alignment whose mask (a-1) is m.
  function automatic logic [AW-1:0] align_up(input logic [AW-1:0] v, input logic [AW-1:0] m);
    align_up = (v + m) & ~m;
  endfunction

  // Mask (a-1) for the largest power of two a not above align; 0 counts as 1.
  function automatic logic [12:0] align_mask(input logic [12:0] al);
    logic [12:0] m;
    m = '0;
    for (int i = 0; i < 13; i++) begin
      if (al[i]) begin
        m = (13'd1 << i) - 13'd1;
      end
    end
    align_mask = m;
  endfunction

  assign tot_eff = (AW'(total_q) < AW'(MAX_PAGES)) ? AW'(total_q) : AW'(MAX_PAGES);
  assign run_end = cand_q + cnt_q;
  assign t_next  = t_q + AW'(1);

  bpa_ram #(.Width(1), .Depth(MAX_PAGES)) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    logic [AW-1:0] start_w, end_w, last_w;
    start_w     = AW'(in_req_i.start_page);
    end_w       = start_w + AW'(in_req_i.page_count);
    last_w      = AW'(last_q);
    state_d     = state_q;
    last_d      = last_q;
    clr_d       = clr_q;
    cand_d      = cand_q;
    t_d         = t_q;
    hi_d        = hi_q;
    end_d       = end_q;
    cnt_d       = cnt_q;
    amask_d     = amask_q;
    pass_d      = pass_q;
    wval_d      = wval_q;
    status_d    = status_q;
    page_d      = page_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rsp_d   = out_rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = t_q[PW-1:0];
    ram_wdata   = wval_q;
    ram_re      = 1'b0;
    ram_raddr   = t_q[PW-1:0];

    case (state_q)
      S_CLR: begin
        // Sweep the map to all free after reset.
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 1'b0;
        clr_d     = clr_q + PW'(1);
        if (AW'(clr_q) == AW'(MAX_PAGES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          status_d = bpa_pkg::ST_BAD;
          page_d   = '0;
          cnt_d    = AW'(in_req_i.page_count);
          state_d  = S_DONE;
          if (in_req_i.page_count != '0) begin
            if (in_req_i.req_type == bpa_pkg::REQ_ALLOC) begin
              // First pass: just past the last allocation up to the total.
              amask_d = AW'(align_mask(in_req_i.align_pages));
              pass_d  = 1'b0;
              hi_d    = tot_eff;
              cand_d  = align_up(last_w + AW'(1), AW'(align_mask(in_req_i.align_pages)));
              state_d = S_CAND;
            end else if ((in_req_i.req_type == bpa_pkg::REQ_FREE ||
                          in_req_i.req_type == bpa_pkg::REQ_RESERVE) &&
                         start_w < tot_eff) begin
              t_d      = start_w;
              end_d    = (end_w > tot_eff) ? tot_eff : end_w;
              wval_d   = (in_req_i.req_type == bpa_pkg::REQ_RESERVE);
              status_d = bpa_pkg::ST_OK;
              state_d  = S_FILL;
            end
          end
        end
      end
      S_CAND: begin
        if (run_end <= hi_q) begin
          t_d     = cand_q;
          state_d = S_RD;
        end else if (!pass_q) begin
          // Second pass: page 0 up to the last allocation page.
          pass_d  = 1'b1;
          hi_d    = (AW'(last_q) < tot_eff) ? AW'(last_q) : tot_eff;
          cand_d  = '0;
        end else begin
          status_d = bpa_pkg::ST_NOFIT;
          state_d  = S_DONE;
        end
      end
      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (ram_rdata) begin
          // Blocked: resume at the next aligned page past the used one.
          cand_d  = align_up(t_next, amask_q);
          state_d = S_CAND;
        end else if (t_next == run_end) begin
          t_d      = cand_q;
          end_d    = run_end;
          wval_d   = 1'b1;
          last_d   = t_q[PW-1:0];
          status_d = bpa_pkg::ST_OK;
          page_d   = cand_q[11:0];
          state_d  = S_FILL;
        end else begin
          t_d     = t_next;
          state_d = S_RD;
        end
      end
      S_FILL: begin
        ram_we = 1'b1;
        t_d    = t_next;
        if (t_next == end_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d           = 1'b1;
          out_rsp_d.status      = status_q;
          out_rsp_d.result_page = page_q;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      total_q     <= bpa_pkg::TotalReset;
      last_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q    <= cand_d;
    t_q       <= t_d;
    hi_q      <= hi_d;
    end_q     <= end_d;
    cnt_q     <= cnt_d;
    amask_q   <= amask_d;
    pass_q    <= pass_d;
    wval_q    <= wval_d;
    status_q  <= status_d;
    page_q    <= page_d;
    out_rsp_q <= out_rsp_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTHESIS
  a_chk_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHK |-> $past(state_q) == S_RD)
    else $error("map check without a preceding read");
  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_FILL || state_q == S_CLR))
    else $error("map written outside fill or clear");
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_DONE)
    else $error("result raised outside done state");
`endif
endmodule
`default_nettype wire
